[src/crcfs_pkg.sv]
// ----------------------------------------------------------------------------
// crcfs_pkg: shared types, constants and the CRC step for the frame sync
// Frame layout, header pattern and CRC-16 (0x8005, MSB-first) byte update.
// ----------------------------------------------------------------------------
`default_nettype none

package crcfs_pkg;

	localparam int FRAME_BYTES = 18;
	localparam int HDR_LEN     = 7;
	localparam int CRC_BYTES   = 16;
	localparam int CNT_W       = $clog2(FRAME_BYTES + 1);
	localparam int IDX_W       = $clog2(CRC_BYTES);

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'h8005;
	localparam logic [15:0] CRC_TOP  = 16'h8000;

	localparam logic [7:0] HDR_PAT [HDR_LEN] = '{
		8'h57, 8'h44, 8'h53, 8'h44, 8'h41, 8'h54, 8'h41
	};

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHECK,
		ST_CRC,
		ST_CMP
	} fsm_state_t;

	typedef struct packed {
		logic init;
		logic step;
	} crc_ctl_t;

	typedef struct packed {
		logic        full;
		logic        hdr_ok;
		logic [15:0] rx_crc;
	} win_status_t;

	function automatic logic [15:0] crc_byte_step(input logic [15:0] crc_in,
	                                              input logic [7:0]  data);
		logic [15:0] c;
		c = crc_in ^ {data, 8'h00};
		for (int b = 0; b < 8; b++) begin
			if ((c & CRC_TOP) != 16'h0000) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

`default_nettype wire

[src/crcfs_window.sv]
// ----------------------------------------------------------------------------
// crcfs_window: byte window and arrival counter
// Shifts received bytes into an 18-byte window, counts bytes since the last
// accepted frame and flags a candidate header.
// ----------------------------------------------------------------------------
`default_nettype none

module crcfs_window (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        shift_en,
	input  wire logic [7:0]                  shift_byte,
	input  wire logic                        clear_cnt,
	input  wire logic [crcfs_pkg::IDX_W-1:0] rd_idx,
	output logic [7:0]                       rd_byte,
	output crcfs_pkg::win_status_t           status,
	output logic [31:0]                      word_x,
	output logic [31:0]                      word_y
);
	import crcfs_pkg::*;

	logic [7:0]       win_q [FRAME_BYTES];
	logic [CNT_W-1:0] cnt_q;
	logic             hdr_match;

	// Byte 0 is the oldest.
	always_ff @(posedge clk) begin
		if (shift_en) begin
			for (int i = 0; i < FRAME_BYTES - 1; i++) begin
				win_q[i] <= win_q[i+1];
			end
			win_q[FRAME_BYTES-1] <= shift_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (clear_cnt) begin
			cnt_q <= '0;
		end else if (shift_en && (cnt_q != CNT_W'(FRAME_BYTES))) begin
			cnt_q <= cnt_q + CNT_W'(1);
		end
	end

	always_comb begin
		hdr_match = 1'b1;
		for (int i = 0; i < HDR_LEN; i++) begin
			if (win_q[i] != HDR_PAT[i]) begin
				hdr_match = 1'b0;
			end
		end
	end

	assign status.full   = (cnt_q == CNT_W'(FRAME_BYTES));
	assign status.hdr_ok = hdr_match;
	assign status.rx_crc = {win_q[17], win_q[16]};
	assign rd_byte       = win_q[{1'b0, rd_idx}];
	assign word_x        = {win_q[11], win_q[10], win_q[9], win_q[8]};
	assign word_y        = {win_q[15], win_q[14], win_q[13], win_q[12]};

endmodule

`default_nettype wire

[src/crcfs_crc_unit.sv]
// ----------------------------------------------------------------------------
// crcfs_crc_unit: shared bytewise CRC-16 engine
// Holds the running CRC and folds in one window byte per step.
// ----------------------------------------------------------------------------
`default_nettype none

module crcfs_crc_unit (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire crcfs_pkg::crc_ctl_t ctl,
	input  wire logic [7:0]          data,
	output logic [15:0]              crc
);
	import crcfs_pkg::*;

	logic [15:0] crc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= CRC_INIT;
		end else if (ctl.init) begin
			crc_q <= CRC_INIT;
		end else if (ctl.step) begin
			crc_q <= crc_byte_step(crc_q, data);
		end
	end

	assign crc = crc_q;

endmodule

`default_nettype wire

[src/crc16_checked_frame_sync.sv]
// ----------------------------------------------------------------------------
// crc16_checked_frame_sync: CRC-checked 18-byte frame finder
// Finds "WDSDATA" frames in a byte stream and emits their two payload words.
// ----------------------------------------------------------------------------
// Input channel: data_byte with in_valid / in_stall, one byte per request.
// Output channel: rot_x_bits / rot_y_bits with out_valid / out_stall, one
// request per frame whose CRC-16 over bytes 0..15 matches bytes 16..17.
// Each byte is taken in ST_IDLE, then the header is checked in the next
// cycle in ST_CHECK. A candidate then runs through the bytewise CRC engine
// in ST_CRC (one window byte per cycle) and a compare step in ST_CMP, and
// the result is visible the cycle after the compare. in_stall is high while
// a byte is being worked on.
// The output register holds one result; a finished frame waits in the
// compare step only while that register is full and out_stall is high.
// Reset clears the byte counter, the sequencer and out_valid; no frame is
// checked until 18 bytes have arrived after reset or after a good frame.
// ----------------------------------------------------------------------------
`default_nettype none

module crc16_checked_frame_sync (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  data_byte,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [31:0]      rot_x_bits,
	output logic [31:0]      rot_y_bits
);
	import crcfs_pkg::*;

	fsm_state_t       state_q, state_d;
	logic [IDX_W-1:0] idx_q;
	win_status_t      win_st;
	crc_ctl_t         crc_ctl;
	logic [7:0]       rd_byte;
	logic [31:0]      word_x, word_y;
	logic [15:0]      crc_val;
	logic             in_take;
	logic             out_free;
	logic             crc_match;
	logic             load_out;
	logic             clear_cnt;
	logic             out_valid_q;
	logic [31:0]      rot_x_q, rot_y_q;

	assign in_take   = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign crc_match = (crc_val == win_st.rx_crc);

	crcfs_window u_window (
		.clk        (clk),
		.arst_n     (arst_n),
		.shift_en   (in_take),
		.shift_byte (data_byte),
		.clear_cnt  (clear_cnt),
		.rd_idx     (idx_q),
		.rd_byte    (rd_byte),
		.status     (win_st),
		.word_x     (word_x),
		.word_y     (word_y)
	);

	crcfs_crc_unit u_crc (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (crc_ctl),
		.data   (rd_byte),
		.crc    (crc_val)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_take) begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (win_st.full && win_st.hdr_ok) begin
					state_d = ST_CRC;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_CRC: begin
				if (idx_q == IDX_W'(CRC_BYTES - 1)) begin
					state_d = ST_CMP;
				end
			end
			ST_CMP: begin
				// hold a good frame until the output register frees up
				if (!crc_match || out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall     = 1'b1;
		crc_ctl.init = 1'b0;
		crc_ctl.step = 1'b0;
		load_out     = 1'b0;
		clear_cnt    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
			end
			ST_CHECK: begin
				crc_ctl.init = 1'b1;
			end
			ST_CRC: begin
				crc_ctl.step = 1'b1;
			end
			ST_CMP: begin
				load_out  = crc_match && out_free;
				clear_cnt = crc_match && out_free;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CRC) begin
				idx_q <= idx_q + IDX_W'(1);
			end else begin
				idx_q <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			rot_x_q <= word_x;
			rot_y_q <= word_y;
		end
	end

	assign out_valid  = out_valid_q;
	assign rot_x_bits = rot_x_q;
	assign rot_y_bits = rot_y_q;

endmodule

`default_nettype wire

[dv/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for crc16_checked_frame_sync
// Feeds a directed list of frames, then random frames, noise and broken
// frames, byte by byte. A local CRC-16 frame finder predicts the payload pair
// of CHECK_MODEL rows, CHECK_TYPED rows carry it; requests are checked in order.
// ----------------------------------------------------------------------------

module testbench;

	import crcfs_pkg::*;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int RANDOM_BYTES = 520;
	localparam int QUIET_AFTER  = 440;
	localparam int HOLD_AT      = 120;
	localparam int LONG_HOLD    = 500;
	localparam int DRAIN_CYCLES = 40;
	localparam int MAX_PRINTS   = 50;

	localparam logic [4:0]  NO_FAULT   = 5'd31;
	localparam logic [31:0] HDR_WORD_X = 32'h4453_4457;
	localparam logic [23:0] HDR_WORD_Y = 24'h41_5441;

	typedef logic [FRAME_BYTES-1:0][7:0] frame_t;

	typedef enum logic [1:0] {
		ROW_FRAME,
		ROW_INNER
	} row_kind_e;

	typedef enum logic [1:0] {
		LEAD_FILL,
		LEAD_NOISE,
		LEAD_PREFIX
	} lead_mode_e;

	typedef enum logic [1:0] {
		CHECK_MODEL,
		CHECK_TYPED
	} check_e;

	typedef struct packed {
		row_kind_e   kind;
		lead_mode_e  lead_mode;
		logic [4:0]  lead;
		logic [7:0]  fill;
		logic [7:0]  b7;
		logic [31:0] x;
		logic [31:0] y;
		logic [4:0]  fault_at;
		logic [7:0]  fault_mask;
		check_e      check;
		logic        want_frame;
		logic [31:0] want_x;
		logic [31:0] want_y;
	} stim_row_t;

	typedef struct packed {
		logic [31:0] x;
		logic [31:0] y;
	} rot_pair_t;

	localparam stim_row_t DIRECTED [10] = '{
		// first frame after reset, all-zero payload
		'{ROW_FRAME, LEAD_FILL, 5'd0, 8'h00, 8'h00, 32'h0000_0000, 32'h0000_0000,
		  NO_FAULT, 8'h00, CHECK_TYPED, 1'b1, 32'h0000_0000, 32'h0000_0000},
		// back to back with the previous frame, all-ones payload
		'{ROW_FRAME, LEAD_FILL, 5'd0, 8'h00, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
		  NO_FAULT, 8'h00, CHECK_TYPED, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
		// low CRC byte off by one bit
		'{ROW_FRAME, LEAD_FILL, 5'd3, 8'hFF, 8'h5A, 32'h1234_5678, 32'h9ABC_DEF0,
		  5'd16, 8'h01, CHECK_TYPED, 1'b0, 32'h0, 32'h0},
		// payload carries a second header
		'{ROW_FRAME, LEAD_FILL, 5'd0, 8'h00, 8'h57, HDR_WORD_X, {8'h00, HDR_WORD_Y},
		  NO_FAULT, 8'h00, CHECK_TYPED, 1'b1, HDR_WORD_X, {8'h00, HDR_WORD_Y}},
		// that inner header gets a valid CRC, but it sits inside the last frame
		'{ROW_INNER, LEAD_FILL, 5'd0, 8'h00, 8'h00, 32'h0, 32'h0,
		  NO_FAULT, 8'h00, CHECK_TYPED, 1'b0, 32'h0, 32'h0},
		'{ROW_FRAME, LEAD_PREFIX, 5'd4, 8'h00, 8'hA5, 32'h8000_0000, 32'h7F80_0000,
		  NO_FAULT, 8'h00, CHECK_MODEL, 1'b0, 32'h0, 32'h0},
		// last header byte bent, CRC matches the bent frame
		'{ROW_FRAME, LEAD_FILL, 5'd0, 8'h00, 8'h00, 32'h0000_0001, 32'hFFFF_FFFE,
		  5'd6, 8'h20, CHECK_TYPED, 1'b0, 32'h0, 32'h0},
		// high CRC byte bad
		'{ROW_FRAME, LEAD_FILL, 5'd0, 8'h00, 8'h3C, 32'hDEAD_BEEF, 32'h0BAD_F00D,
		  5'd17, 8'h80, CHECK_TYPED, 1'b0, 32'h0, 32'h0},
		'{ROW_FRAME, LEAD_FILL, 5'd0, 8'h00, 8'hC3, 32'hCAFE_F00D, 32'h1357_9BDF,
		  NO_FAULT, 8'h00, CHECK_MODEL, 1'b0, 32'h0, 32'h0},
		// payload byte damaged after the CRC was formed
		'{ROW_FRAME, LEAD_NOISE, 5'd2, 8'h00, 8'h00, 32'h0F0F_0F0F, 32'hF0F0_F0F0,
		  5'd10, 8'h40, CHECK_TYPED, 1'b0, 32'h0, 32'h0}
	};

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	logic [7:0]  data_byte = 8'h00;
	logic        out_stall = 1'b0;
	logic        in_stall;
	logic        out_valid;
	logic [31:0] rot_x_bits;
	logic [31:0] rot_y_bits;

	// frame finder state
	frame_t      win       = '0;
	logic [4:0]  since_ok  = '0;
	rot_pair_t   words_due [$];
	rot_pair_t   due;

	bit          typed_row       = 1'b0;
	bit          quiet           = 1'b0;
	bit          long_hold_armed = 1'b0;
	int          mismatches      = 0;
	int          bytes_sent      = 0;
	int          frames_found    = 0;
	int          crc_rejects     = 0;
	int          results_seen    = 0;
	int          cycle_count     = 0;
	int          in_hold_run     = 0;
	int          in_hold_max     = 0;

	crc16_checked_frame_sync i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.data_byte  (data_byte),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.rot_x_bits (rot_x_bits),
		.rot_y_bits (rot_y_bits)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// CRC-16 over bytes 0..15, bit-serial, MSB first
	function automatic logic [15:0] frame_crc(input frame_t f);
		logic [15:0] c;
		logic        fb;
		c = CRC_INIT;
		for (int i = 0; i < CRC_BYTES; i++) begin
			for (int k = 7; k >= 0; k--) begin
				fb = c[15] ^ f[i][k];
				c  = {c[14:0], 1'b0};
				if (fb) begin
					c = c ^ CRC_POLY;
				end
			end
		end
		return c;
	endfunction

	function automatic void predict_byte(input logic [7:0] b);
		logic [15:0] crc;
		logic        hdr_hit;
		win = {b, win[FRAME_BYTES-1:1]};
		if (since_ok < FRAME_BYTES) begin
			since_ok++;
		end
		if (since_ok != FRAME_BYTES) begin
			return;
		end
		hdr_hit = 1'b1;
		for (int i = 0; i < HDR_LEN; i++) begin
			if (win[i] != HDR_PAT[i]) begin
				hdr_hit = 1'b0;
			end
		end
		if (!hdr_hit) begin
			return;
		end
		crc = frame_crc(win);
		if (crc != {win[17], win[16]}) begin
			crc_rejects++;
			return;
		end
		since_ok = '0;
		frames_found++;
		if (!typed_row) begin
			words_due.push_back('{x: {win[11], win[10], win[9], win[8]},
			                      y: {win[15], win[14], win[13], win[12]}});
		end
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
	                               input logic [31:0] want);
		mismatches++;
		if (mismatches <= MAX_PRINTS) begin
			$display("MISMATCH at %0t: %s got %h want %h", $time, what, got, want);
		end
	endtask

	// enter and leave at a falling edge
	task automatic send_byte(input logic [7:0] b);
		int gap;
		if (!quiet && $urandom_range(0, 9) == 0) begin
			gap = $urandom_range(1, 3);
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid  <= 1'b1;
		data_byte <= b;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
		predict_byte(b);
		bytes_sent++;
		@(negedge clk);
	endtask

	task automatic run_row(input stim_row_t r);
		logic [7:0]  seq [$];
		frame_t      f;
		logic [15:0] crc;
		f = '0;
		typed_row = (r.check == CHECK_TYPED);
		if (typed_row && r.want_frame) begin
			words_due.push_back('{x: r.want_x, y: r.want_y});
		end
		if (r.kind == ROW_INNER) begin
			// complete the candidate that starts at payload byte 8 of the last frame
			for (int i = 0; i < 10; i++) begin
				f[i] = win[i + 8];
			end
			for (int i = 10; i < CRC_BYTES; i++) begin
				f[i] = 8'($urandom);
			end
			crc = frame_crc(f);
			{f[17], f[16]} = crc;
			for (int i = 10; i < FRAME_BYTES; i++) begin
				seq.push_back(f[i]);
			end
		end else begin
			for (int i = 0; i < r.lead; i++) begin
				case (r.lead_mode)
					LEAD_FILL: begin
						seq.push_back(r.fill);
					end
					LEAD_NOISE: begin
						seq.push_back(8'($urandom));
					end
					default: begin
						seq.push_back(HDR_PAT[i % HDR_LEN]);
					end
				endcase
			end
			for (int i = 0; i < HDR_LEN; i++) begin
				f[i] = HDR_PAT[i];
			end
			f[7] = r.b7;
			{f[11], f[10], f[9], f[8]}     = r.x;
			{f[15], f[14], f[13], f[12]} = r.y;
			// header damage goes in before the CRC, everything else after it
			if (r.fault_at < HDR_LEN) begin
				f[r.fault_at] ^= r.fault_mask;
			end
			crc = frame_crc(f);
			{f[17], f[16]} = crc;
			if (r.fault_at != NO_FAULT && r.fault_at >= HDR_LEN) begin
				f[r.fault_at] ^= r.fault_mask;
			end
			for (int i = 0; i < FRAME_BYTES; i++) begin
				seq.push_back(f[i]);
			end
		end
		foreach (seq[k]) begin
			send_byte(seq[k]);
		end
		typed_row = 1'b0;
	endtask

	function automatic stim_row_t random_row();
		stim_row_t r;
		r = '0;
		r.kind  = ROW_FRAME;
		r.check = CHECK_MODEL;
		case ($urandom_range(0, 3))
			0: begin
				r.lead_mode = LEAD_NOISE;
				r.lead      = 5'($urandom_range(1, 5));
			end
			1: begin
				r.lead_mode = LEAD_PREFIX;
				r.lead      = 5'($urandom_range(1, HDR_LEN - 1));
			end
			default: begin
				r.lead_mode = LEAD_FILL;
				r.lead      = 5'd0;
			end
		endcase
		r.b7 = 8'($urandom);
		r.x  = $urandom;
		r.y  = $urandom;
		if ($urandom_range(0, 7) == 0) begin
			r.x = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0000_0000;
		end
		if ($urandom_range(0, 7) == 0) begin
			r.y = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0000_0000;
		end
		r.fault_mask = 8'($urandom_range(1, 255));
		case ($urandom_range(0, 9))
			0: begin
				r.fault_at = 5'($urandom_range(0, HDR_LEN - 1));
			end
			1, 2: begin
				r.fault_at = 5'($urandom_range(HDR_LEN, FRAME_BYTES - 1));
			end
			default: begin
				r.fault_at = NO_FAULT;
			end
		endcase
		return r;
	endfunction

	// output side: short random stalls, one long hold-off
	initial begin
		int hold_left;
		hold_left = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				hold_left--;
			end else if (long_hold_armed) begin
				long_hold_armed = 1'b0;
				out_stall <= 1'b1;
				hold_left = LONG_HOLD - 1;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				out_stall <= 1'b1;
				hold_left = $urandom_range(1, 3) - 1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("no progress after %0d cycles", cycle_count);
			$display("testbench failed");
			$finish;
		end else begin
			if (in_valid && in_stall) begin
				in_hold_run++;
				if (in_hold_run > in_hold_max) begin
					in_hold_max = in_hold_run;
				end
			end else begin
				in_hold_run = 0;
			end
			if (arst_n && out_valid && !out_stall) begin
				results_seen++;
				if (words_due.size() == 0) begin
					report_mismatch("request with nothing due, rot_x_bits", rot_x_bits, 32'h0);
				end else begin
					due = words_due.pop_front();
					if (rot_x_bits !== due.x) begin
						report_mismatch("rot_x_bits", rot_x_bits, due.x);
					end
					if (rot_y_bits !== due.y) begin
						report_mismatch("rot_y_bits", rot_y_bits, due.y);
					end
				end
			end
		end
	end

	initial begin
		stim_row_t r;
		stim_row_t inner_row;
		int        dir_bytes;
		bit        hold_done;
		hold_done = 1'b0;
		inner_row = '0;
		inner_row.kind  = ROW_INNER;
		inner_row.check = CHECK_MODEL;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		for (int n = 0; n < $size(DIRECTED); n++) begin
			run_row(DIRECTED[n]);
		end
		dir_bytes = bytes_sent;
		while (bytes_sent - dir_bytes < RANDOM_BYTES) begin
			quiet = (bytes_sent - dir_bytes >= QUIET_AFTER);
			if (!hold_done && bytes_sent - dir_bytes >= HOLD_AT) begin
				long_hold_armed = 1'b1;
				hold_done       = 1'b1;
			end
			r = random_row();
			if ($urandom_range(0, 9) == 0) begin
				// hide a header in the payload, then give it a matching CRC
				r.x        = HDR_WORD_X;
				r.y[23:0]  = HDR_WORD_Y;
				r.fault_at = NO_FAULT;
				run_row(r);
				run_row(inner_row);
			end else begin
				run_row(r);
			end
		end
		quiet = 1'b1;
		in_valid <= 1'b0;
		while (words_due.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("sent %0d bytes: %0d frames found, %0d headers rejected on CRC",
		         bytes_sent, frames_found, crc_rejects);
		$display("checked %0d output requests; longest input hold-off %0d cycles",
		         results_seen, in_hold_max);
		if (mismatches == 0) begin
			$display("testbench passed");
		end else begin
			$display("testbench failed");
		end
		$finish;
	end

endmodule

[crc16_checked_frame_sync.f]
src/crcfs_pkg.sv
src/crcfs_window.sv
src/crcfs_crc_unit.sv
src/crc16_checked_frame_sync.sv
dv/testbench.sv
